// File: rtl/rtp_audio_level_extension_parser_defines.svh
// ----------------------------------------------------------------------------
// RTP audio level parser - assertion macros
// Shared property shapes for the checker; clocked, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef RTP_AUDIO_LEVEL_EXTENSION_PARSER_DEFINES_SVH
`define RTP_AUDIO_LEVEL_EXTENSION_PARSER_DEFINES_SVH

// Same-cycle implication
`define RALEP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define RALEP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ralep_pkg.sv
// ----------------------------------------------------------------------------
// RTP audio level parser - package
// Widths, protocol constants, parse phases and the result record.
// ----------------------------------------------------------------------------
package ralep_pkg;

  // Packet length / byte position width (8..16)
  localparam int LENGTH_BITS = 16;
  localparam int POS_W       = LENGTH_BITS;
  localparam int EXT_W       = 16;
  // compare width: holds position + 1 and extension end + 1
  localparam int CMP_W       = 17;
  // extension end before range check: e0 + 4 + 4 * 16-bit length
  localparam int END_W       = 19;

  localparam logic [POS_W-1:0] POS_MAX        = '1;
  localparam logic [POS_W-1:0] POS_PT         = POS_W'(1);
  localparam logic [POS_W-1:0] POS_SSRC_FIRST = POS_W'(8);
  localparam logic [POS_W-1:0] POS_SSRC_LAST  = POS_W'(11);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // RTP constants
  localparam logic [1:0]  RTP_VERSION      = 2'd2;
  localparam logic [6:0]  MIN_LEN          = 7'd12;
  localparam logic [15:0] ONE_BYTE_PROFILE = 16'hBEDE;
  localparam logic [3:0]  ID_PAD           = 4'd0;
  localparam logic [3:0]  ID_STOP          = 4'd15;

  // Register reset values
  localparam logic [6:0] PT_RESET       = 7'd111;
  localparam logic [3:0] LEVEL_ID_RESET = 4'd1;

  typedef enum logic [2:0] {
    PH_HEAD   = 3'd0,
    PH_CSRC   = 3'd1,
    PH_EXTHDR = 3'd2,
    PH_WALK   = 3'd3,
    PH_LEVEL  = 3'd4,
    PH_IDLE   = 3'd5
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REWRITE  = 2'd0,
    CFG_PT       = 2'd1,
    CFG_LEVEL_ID = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_last;
    logic        ssrc_valid;
    logic [31:0] ssrc_value;
    logic        level_found;
    logic [6:0]  audio_level;
    logic        voice_flag;
  } result_t;

endpackage

// File: rtl/ralep_if.sv
// ----------------------------------------------------------------------------
// RTP audio level parser - channel interfaces
// Packet byte input, per-byte report output and register write channel.
// ----------------------------------------------------------------------------

// Packet bytes in
interface ralep_pkt_if;
  logic        valid;
  logic        ready;
  logic [7:0]  in_byte;
  logic        in_last;
  logic [15:0] packet_length;
  logic        want_voice;

  modport source (output valid, in_byte, in_last, packet_length, want_voice,
                  input ready);
  modport sink   (input valid, in_byte, in_last, packet_length, want_voice,
                  output ready);
endinterface

// Bytes out with end-of-packet report
interface ralep_rep_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        ssrc_valid;
  logic [31:0] ssrc_value;
  logic        level_found;
  logic [6:0]  audio_level;
  logic        voice_flag;

  modport source (output valid, out_byte, out_last, ssrc_valid, ssrc_value,
                  level_found, audio_level, voice_flag, input ready);
  modport sink   (input valid, out_byte, out_last, ssrc_valid, ssrc_value,
                  level_found, audio_level, voice_flag, output ready);
endinterface

// Register writes
interface ralep_cfg_if;
  import ralep_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/rtp_audio_level_extension_parser.sv
// ----------------------------------------------------------------------------
// RTP audio level extension parser
// Parses RTP header, SSRC and one-byte header extension on the fly, reports
// the audio level element on the final byte and optionally rewrites its
// voice activity bit. Every byte passes through.
// ----------------------------------------------------------------------------
//
//  channel  | role | request carries
//  ---------+------+------------------------------------------------------
//  pkt      | sink | in_byte, in_last, packet_length, want_voice
//  report   | src  | out_byte, out_last, ssrc/level report (on final byte)
//  cfg      | sink | index, data (rewrite_enable, payload_type_match,
//           |      |              level_ext_id); always ready
//
//  One byte per clock sustained while report keeps up. Parse state and the
//  result are captured at the accepting edge; the result is registered in the
//  output register, or in the skid register while report stalls. The skid
//  register keeps pkt.ready high while only the output register waits; ready
//  drops only while the skid register is full. Synchronous reset clears parse
//  state and both output valid flags and sets the registers to reset values.
module rtp_audio_level_extension_parser (
  input  logic         clk,
  input  logic         rst,
  ralep_pkt_if.sink    pkt,
  ralep_rep_if.source  report,
  ralep_cfg_if.sink    cfg
);
  import ralep_pkg::*;

  // Configuration registers
  logic       rewrite_enable;
  logic [6:0] payload_type_match;
  logic [3:0] level_ext_id;

  // Per-packet parse state
  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] pkt_len;
  phase_t           phase, phase_next;
  logic [3:0]       csrc_count, csrc_count_next;
  logic             header_ok, header_ok_next;
  logic [31:0]      ssrc_shift, ssrc_shift_next;
  logic [15:0]      profile_word, profile_word_next;
  logic [EXT_W-1:0] ext_end_position, ext_end_position_next;
  logic [4:0]       element_bytes_left, element_bytes_left_next;
  logic [7:0]       found_level, found_level_next;
  logic             level_seen, level_seen_next;
  logic             ssrc_seen, ssrc_seen_next;

  // Output register and skid stage
  result_t result, out_data, skid_data;
  logic    out_valid, skid_valid;
  logic    pkt_fire;
  logic [7:0] ob;

  // Shared decode
  logic             pos_zero;
  logic [POS_W-1:0] len_cur;
  logic [3:0]       csrc_cur;
  logic [6:0]       e0;
  logic [CMP_W-1:0] pos_inc_c, len_c, e0_c, ext_end_c, room;
  logic [POS_W-1:0] k;
  logic [15:0]      ext_shift;
  logic [END_W-1:0] ext_span;
  logic             ext_ok, hdr_first_ok, elem_overrun, walk_done;
  logic [3:0]       id, elen;

  assign pkt_fire   = pkt.valid && pkt.ready;
  assign pkt.ready  = !skid_valid;
  assign cfg.ready  = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rewrite_enable     <= 1'b0;
      payload_type_match <= PT_RESET;
      level_ext_id       <= LEVEL_ID_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_REWRITE:  rewrite_enable     <= cfg.data[0];
        CFG_PT:       payload_type_match <= cfg.data[6:0];
        CFG_LEVEL_ID: level_ext_id       <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

  // Decode of the current byte against the state
  always_comb begin
    pos_zero  = (byte_position == '0);
    len_cur   = pos_zero ? pkt.packet_length[POS_W-1:0] : pkt_len;
    csrc_cur  = (phase == PH_HEAD && pos_zero) ? pkt.in_byte[3:0] : csrc_count;
    e0        = MIN_LEN + 7'({csrc_cur, 2'b00});
    pos_inc_c = CMP_W'(byte_position) + CMP_W'(1);
    len_c     = CMP_W'(len_cur);
    e0_c      = CMP_W'(e0);
    ext_end_c = CMP_W'(ext_end_position);
    k         = byte_position - POS_W'(e0);
    ext_shift = {ext_end_position[7:0], pkt.in_byte};
    ext_span  = END_W'(e0) + END_W'(4) + END_W'({ext_shift, 2'b00});
    ext_ok    = (profile_word == ONE_BYTE_PROFILE) &&
                (ext_span <= END_W'(len_cur)) && (ext_span > END_W'(pos_inc_c));
    hdr_first_ok = (pkt.in_byte[7:6] == RTP_VERSION) && pkt.in_byte[4] &&
                   (len_c >= CMP_W'(MIN_LEN)) && (e0_c <= len_c);
    id           = pkt.in_byte[7:4];
    elen         = pkt.in_byte[3:0];
    room         = ext_end_c - pos_inc_c;
    elem_overrun = room < CMP_W'({1'b0, elen} + 5'd1);
    walk_done    = pos_inc_c >= ext_end_c;
  end

  // Parse phase: next state
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HEAD: begin
        if (byte_position == POS_SSRC_LAST) begin
          if (header_ok && len_c >= e0_c + CMP_W'(4))
            phase_next = (csrc_count != 4'd0) ? PH_CSRC : PH_EXTHDR;
          else
            phase_next = PH_IDLE;
        end
      end
      PH_CSRC: begin
        if (pos_inc_c >= e0_c) phase_next = PH_EXTHDR;
      end
      PH_EXTHDR: begin
        if (k >= POS_W'(3)) phase_next = ext_ok ? PH_WALK : PH_IDLE;
      end
      PH_WALK: begin
        if (element_bytes_left == 5'd0 && id == ID_STOP)
          phase_next = PH_IDLE;
        else if (element_bytes_left == 5'd0 && id != ID_PAD && elem_overrun)
          phase_next = PH_IDLE;
        else if (element_bytes_left == 5'd0 && id != ID_PAD && id == level_ext_id)
          phase_next = PH_LEVEL;
        else if (walk_done)
          phase_next = PH_IDLE;
      end
      PH_LEVEL: phase_next = PH_IDLE;
      PH_IDLE:  phase_next = PH_IDLE;
      default:  phase_next = PH_IDLE;
    endcase
  end

  // Parse phase: field updates and byte rewrite
  always_comb begin
    csrc_count_next         = csrc_count;
    header_ok_next          = header_ok;
    ssrc_shift_next         = ssrc_shift;
    profile_word_next       = profile_word;
    ext_end_position_next   = ext_end_position;
    element_bytes_left_next = element_bytes_left;
    found_level_next        = found_level;
    level_seen_next         = level_seen;
    ssrc_seen_next          = ssrc_seen;
    ob                      = pkt.in_byte;
    unique case (phase)
      PH_HEAD: begin
        if (pos_zero) begin
          csrc_count_next = pkt.in_byte[3:0];
          header_ok_next  = hdr_first_ok;
        end
        if (byte_position == POS_PT && pkt.in_byte[6:0] != payload_type_match)
          header_ok_next = 1'b0;
        if (byte_position >= POS_SSRC_FIRST)
          ssrc_shift_next = {ssrc_shift[23:0], pkt.in_byte};
        if (byte_position == POS_SSRC_LAST)
          ssrc_seen_next = (len_c >= CMP_W'(MIN_LEN));
      end
      PH_EXTHDR: begin
        if (k < POS_W'(2)) begin
          profile_word_next = {profile_word[7:0], pkt.in_byte};
        end else begin
          ext_end_position_next = ext_shift;
          if (k >= POS_W'(3) && ext_ok) ext_end_position_next = EXT_W'(ext_span);
        end
      end
      PH_WALK: begin
        if (element_bytes_left != 5'd0)
          element_bytes_left_next = element_bytes_left - 5'd1;
        else if (id != ID_STOP && id != ID_PAD && !elem_overrun && id != level_ext_id)
          element_bytes_left_next = {1'b0, elen} + 5'd1;
      end
      PH_LEVEL: begin
        found_level_next = pkt.in_byte;
        level_seen_next  = 1'b1;
        if (rewrite_enable) ob = {pkt.want_voice, pkt.in_byte[6:0]};
      end
      default: ;
    endcase
  end

  // Result record; report only on the final byte
  always_comb begin
    result.out_byte    = ob;
    result.out_last    = pkt.in_last;
    result.ssrc_valid  = pkt.in_last && ssrc_seen_next;
    result.ssrc_value  = (pkt.in_last && ssrc_seen_next) ? ssrc_shift_next : 32'd0;
    result.level_found = pkt.in_last && level_seen_next;
    result.audio_level = (pkt.in_last && level_seen_next) ? found_level_next[6:0] : 7'd0;
    result.voice_flag  = pkt.in_last && level_seen_next && found_level_next[7];
  end

  // Parse state registers; everything clears after the final byte
  always_ff @(posedge clk) begin
    if (rst || (pkt_fire && pkt.in_last)) begin
      byte_position      <= '0;
      pkt_len            <= '0;
      phase              <= PH_HEAD;
      csrc_count         <= 4'd0;
      header_ok          <= 1'b0;
      ssrc_shift         <= 32'd0;
      profile_word       <= 16'd0;
      ext_end_position   <= '0;
      element_bytes_left <= 5'd0;
      found_level        <= 8'd0;
      level_seen         <= 1'b0;
      ssrc_seen          <= 1'b0;
    end else if (pkt_fire) begin
      if (byte_position != POS_MAX) byte_position <= byte_position + POS_W'(1);
      pkt_len            <= len_cur;
      phase              <= phase_next;
      csrc_count         <= csrc_count_next;
      header_ok          <= header_ok_next;
      ssrc_shift         <= ssrc_shift_next;
      profile_word       <= profile_word_next;
      ext_end_position   <= ext_end_position_next;
      element_bytes_left <= element_bytes_left_next;
      found_level        <= found_level_next;
      level_seen         <= level_seen_next;
      ssrc_seen          <= ssrc_seen_next;
    end
  end

  // Output register and skid: valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || report.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= pkt_fire;
      end
    end else if (pkt_fire) begin
      skid_valid <= 1'b1;
    end
  end

  // Output register and skid: payload
  always_ff @(posedge clk) begin
    if (!out_valid || report.ready) begin
      if (skid_valid)    out_data <= skid_data;
      else if (pkt_fire) out_data <= result;
    end else if (pkt_fire) begin
      skid_data <= result;
    end
  end

  assign report.valid       = out_valid;
  assign report.out_byte    = out_data.out_byte;
  assign report.out_last    = out_data.out_last;
  assign report.ssrc_valid  = out_data.ssrc_valid;
  assign report.ssrc_value  = out_data.ssrc_value;
  assign report.level_found = out_data.level_found;
  assign report.audio_level = out_data.audio_level;
  assign report.voice_flag  = out_data.voice_flag;

endmodule

// File: rtl/ralep_checker.sv
// ----------------------------------------------------------------------------
// RTP audio level parser - port checker
// Watches the report channel of the parser; bound to the parser module.
// ----------------------------------------------------------------------------
`include "rtp_audio_level_extension_parser_defines.svh"

module ralep_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic [7:0]  out_byte,
  input logic        out_last,
  input logic        ssrc_valid,
  input logic [31:0] ssrc_value,
  input logic        level_found,
  input logic [6:0]  audio_level,
  input logic        voice_flag
);

  // report fields stay quiet until the final byte
  `RALEP_ASSERT_IMPL(a_quiet_midpacket, clk, rst, valid && !out_last, !ssrc_valid && !level_found && ssrc_value == 32'd0 && audio_level == 7'd0 && !voice_flag, "report set on non-final byte")

  // no SSRC read means a zero SSRC
  `RALEP_ASSERT_IMPL(a_ssrc_zero, clk, rst, valid && !ssrc_valid, ssrc_value == 32'd0, "SSRC non-zero without ssrc_valid")

  // no level element means zero level and voice bit
  `RALEP_ASSERT_IMPL(a_level_zero, clk, rst, valid && !level_found, audio_level == 7'd0 && !voice_flag, "level fields set without level_found")

  // a stalled request holds
  `RALEP_ASSERT_NEXT(a_report_hold, clk, rst, valid && !ready, valid && $stable(out_byte) && $stable(out_last), "stalled report changed")

endmodule

bind rtp_audio_level_extension_parser ralep_checker u_ralep_checker (
  .clk         (clk),
  .rst         (rst),
  .valid       (report.valid),
  .ready       (report.ready),
  .out_byte    (report.out_byte),
  .out_last    (report.out_last),
  .ssrc_valid  (report.ssrc_valid),
  .ssrc_value  (report.ssrc_value),
  .level_found (report.level_found),
  .audio_level (report.audio_level),
  .voice_flag  (report.voice_flag)
);

// File: sim/ralep_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RTP audio level parser - testbench scoreboard
// Predicts the per-byte report of the parser from the accepted packet bytes
// and the register settings, and checks each report against it in order.
// ----------------------------------------------------------------------------
package ralep_tb_pkg;
  import ralep_pkg::*;

  // One accepted packet byte request
  typedef struct packed {
    bit [7:0]  data;
    bit        last;
    bit [15:0] length;
    bit        want;
  } byte_req_t;

  class audio_level_scoreboard;
    // register copies
    bit          rewrite_en;
    bit [6:0]    pt_match;
    bit [3:0]    level_id;
    // per-packet parse state
    bit [15:0]   pos;
    phase_t      phase;
    bit [3:0]    csrc_n;
    bit          hdr_ok;
    bit [31:0]   ssrc;
    bit [15:0]   profile;
    int unsigned ext_end;
    bit [4:0]    elem_left;
    bit [7:0]    level_byte;
    bit          level_seen;
    bit          ssrc_seen;
    bit [15:0]   pkt_len;

    result_t     pending_reports[$];
    int unsigned failures;

    function new();
      rewrite_en = 1'b0;
      pt_match   = PT_RESET;
      level_id   = LEVEL_ID_RESET;
      failures   = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      pos        = '0;
      phase      = PH_HEAD;
      csrc_n     = '0;
      hdr_ok     = 1'b0;
      ssrc       = '0;
      profile    = '0;
      ext_end    = 0;
      elem_left  = '0;
      level_byte = '0;
      level_seen = 1'b0;
      ssrc_seen  = 1'b0;
      pkt_len    = '0;
    endfunction

    function void write_reg(cfg_idx_t idx, bit [6:0] value);
      case (idx)
        CFG_REWRITE:  rewrite_en = value[0];
        CFG_PT:       pt_match   = value;
        CFG_LEVEL_ID: level_id   = value[3:0];
        default: ;
      endcase
    endfunction

    // Advance the parse by one byte and queue the report it produces
    function void note_byte(byte_req_t r);
      int unsigned p, hdr_end, k, ext_stop, e_len;
      bit [3:0]    e_id;
      result_t     predicted;
      p = pos;
      predicted = '0;
      predicted.out_byte = r.data;
      if (p == 0) pkt_len = r.length;
      hdr_end = 12 + 4 * csrc_n;

      case (phase)
        PH_HEAD: begin
          if (p == 0) begin
            csrc_n  = r.data[3:0];
            hdr_end = 12 + 4 * csrc_n;
            hdr_ok  = (r.data[7:6] == RTP_VERSION) && r.data[4] &&
                      (pkt_len >= MIN_LEN) && (hdr_end <= pkt_len);
          end
          if (p == POS_PT && r.data[6:0] != pt_match) hdr_ok = 1'b0;
          if (p >= POS_SSRC_FIRST) ssrc = {ssrc[23:0], r.data};
          if (p == POS_SSRC_LAST) begin
            ssrc_seen = (pkt_len >= MIN_LEN);
            if (hdr_ok && pkt_len >= hdr_end + 4)
              phase = (csrc_n != 0) ? PH_CSRC : PH_EXTHDR;
            else
              phase = PH_IDLE;
          end
        end
        PH_CSRC: begin
          if (p + 1 >= hdr_end) phase = PH_EXTHDR;
        end
        PH_EXTHDR: begin
          k = p - hdr_end;
          if (k < 2) begin
            profile = {profile[7:0], r.data};
          end else begin
            ext_end = ((ext_end << 8) | r.data) & 32'hFFFF;
            if (k >= 3) begin
              ext_stop = hdr_end + 4 + 4 * ext_end;
              if (profile == ONE_BYTE_PROFILE && ext_stop <= pkt_len && ext_stop > p + 1) begin
                ext_end = ext_stop;
                phase   = PH_WALK;
              end else begin
                phase = PH_IDLE;
              end
            end
          end
        end
        PH_WALK: begin
          if (elem_left != 0) begin
            elem_left = elem_left - 1;
          end else begin
            e_id  = r.data[7:4];
            e_len = r.data[3:0];
            if (e_id == ID_STOP) begin
              phase = PH_IDLE;
            end else if (e_id != ID_PAD) begin
              if (ext_end - (p + 1) < e_len + 1) phase = PH_IDLE;
              else if (e_id == level_id) phase = PH_LEVEL;
              else elem_left = 5'(e_len + 1);
            end
          end
          if (phase == PH_WALK && p + 1 >= ext_end) phase = PH_IDLE;
        end
        PH_LEVEL: begin
          level_byte = r.data;
          level_seen = 1'b1;
          if (rewrite_en) predicted.out_byte = {r.want, r.data[6:0]};
          phase = PH_IDLE;
        end
        default: ;
      endcase

      // report fields only carry meaning on the final byte
      predicted.out_last    = r.last;
      predicted.ssrc_valid  = r.last && ssrc_seen;
      predicted.ssrc_value  = (r.last && ssrc_seen) ? ssrc : 32'd0;
      predicted.level_found = r.last && level_seen;
      predicted.audio_level = (r.last && level_seen) ? level_byte[6:0] : 7'd0;
      predicted.voice_flag  = r.last && level_seen && level_byte[7];
      pending_reports.push_back(predicted);

      if (r.last) clear_packet();
      else if (pos != POS_MAX) pos = pos + 1;
    endfunction

    function string show(result_t v);
      return $sformatf("byte %h last %b ssrc %b/%h level %b/%h voice %b",
                       v.out_byte, v.out_last, v.ssrc_valid, v.ssrc_value,
                       v.level_found, v.audio_level, v.voice_flag);
    endfunction

    // Compare one accepted report with the oldest prediction
    function void check_report(result_t got);
      result_t want_rep;
      if (pending_reports.size() == 0) begin
        failures++;
        if (failures <= 10) $display("ERROR: report with none pending: %s", show(got));
        return;
      end
      want_rep = pending_reports.pop_front();
      if (got.out_byte !== want_rep.out_byte || got.out_last !== want_rep.out_last ||
          got.ssrc_valid !== want_rep.ssrc_valid || got.ssrc_value !== want_rep.ssrc_value ||
          got.level_found !== want_rep.level_found ||
          got.audio_level !== want_rep.audio_level ||
          got.voice_flag !== want_rep.voice_flag) begin
        failures++;
        if (failures <= 10)
          $display("ERROR: report mismatch\n  expected %s\n  actual   %s",
                   show(want_rep), show(got));
      end
    endfunction
  endclass

endpackage

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RTP audio level parser - testbench
// Streams directed and random RTP packets (well-formed, damaged and noise)
// through the parser under several register settings and idle patterns,
// and checks every passed-through byte and end-of-packet report.
// ----------------------------------------------------------------------------
module testbench;
  import ralep_pkg::*;
  import ralep_tb_pkg::*;

  typedef enum int {
    FL_NONE, FL_VERSION, FL_XBIT, FL_PT, FL_CSRC_OVER, FL_EXT_SHORT, FL_EXT_LONG,
    FL_PROFILE, FL_EXT_EMPTY, FL_OVERRUN, FL_EARLY_LAST, FL_LEN_MISMATCH, FL_NOISE
  } flaw_t;

  logic clk;
  logic rst;

  ralep_pkt_if pkt ();
  ralep_rep_if report ();
  ralep_cfg_if cfg ();

  rtp_audio_level_extension_parser dut (
    .clk    (clk),
    .rst    (rst),
    .pkt    (pkt),
    .report (report),
    .cfg    (cfg)
  );

  audio_level_scoreboard sb = new();

  int        idle_pct    = 0;
  int        stall_pct   = 0;
  int        hold_cycles = 0;
  bit [7:0]  pkt_q[$];
  bit [15:0] len_field;

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Report side back-pressure, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      report.ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      report.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Accepted requests feed the predictor before reports are checked
  always @(posedge clk) begin
    if (!rst) begin
      if (pkt.valid && pkt.ready)
        sb.note_byte({pkt.in_byte, pkt.in_last, pkt.packet_length, pkt.want_voice});
      if (report.valid && report.ready)
        sb.check_report({report.out_byte, report.out_last, report.ssrc_valid,
                         report.ssrc_value, report.level_found, report.audio_level,
                         report.voice_flag});
    end
  end

  task automatic send_byte(input bit [7:0] d, input bit last, input bit [15:0] len,
                           input bit want);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      pkt.valid <= 1'b0;
    end
    @(negedge clk);
    pkt.valid         <= 1'b1;
    pkt.in_byte       <= d;
    pkt.in_last       <= last;
    pkt.packet_length <= len;
    pkt.want_voice    <= want;
    do @(posedge clk); while (!(pkt.valid && pkt.ready));
  endtask

  task automatic send_packet(input bit want);
    for (int i = 0; i < pkt_q.size(); i++)
      send_byte(pkt_q[i], i == pkt_q.size() - 1, len_field, want);
  endtask

  // Stop offering bytes and wait for every report to come back
  task automatic settle();
    @(negedge clk);
    pkt.valid <= 1'b0;
    while (sb.pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input bit [6:0] value);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic set_config(input bit rewrite, input bit [6:0] pt, input bit [3:0] id);
    write_reg(CFG_REWRITE, {6'd0, rewrite});
    write_reg(CFG_PT, pt);
    write_reg(CFG_LEVEL_ID, {3'd0, id});
  endtask

  // Build one packet into pkt_q; fixed_level >= 0 gives a fixed extension
  // (padding, other element, level element, stop id) with that level byte
  function automatic void build_packet(input flaw_t fl, input int fixed_level);
    bit [7:0] ext[$];
    int       n_csrc, e0, n_el, ln, words, orig, cut, idx;
    bit [3:0] other;
    pkt_q.delete();
    if (fl == FL_NOISE) begin
      repeat ($urandom_range(1, 30)) pkt_q.push_back(8'($urandom));
      len_field = $urandom_range(0, 1) ? 16'(pkt_q.size()) : 16'($urandom_range(1, 65535));
      return;
    end

    n_csrc = (fixed_level >= 0) ? 0 :
             ($urandom_range(0, 7) == 0) ? $urandom_range(2, 15) : $urandom_range(0, 1);
    e0 = 12 + 4 * n_csrc;
    other = 4'($urandom_range(1, 14));
    if (other == sb.level_id) other = (other == 4'd14) ? 4'd1 : other + 4'd1;

    // extension body, never more than 16 bytes
    if (fixed_level >= 0) begin
      ext.push_back({ID_PAD, 4'd0});
      ext.push_back({other, 4'd1});
      ext.push_back(8'($urandom));
      ext.push_back(8'($urandom));
      ext.push_back({sb.level_id, 4'd0});
      ext.push_back(8'(fixed_level));
      ext.push_back({ID_STOP, 4'd0});
    end else begin
      n_el = $urandom_range(0, 4);
      for (int i = 0; i < n_el; i++) begin
        case ($urandom_range(0, 9))
          0, 1: ext.push_back({ID_PAD, 4'd0});
          2, 3, 4, 5: begin
            ln = $urandom_range(0, 1);
            ext.push_back({sb.level_id, 4'(ln)});
            repeat (ln + 1) ext.push_back(8'($urandom));
          end
          6: ext.push_back({ID_STOP, 4'($urandom)});
          default: begin
            ln = $urandom_range(0, 2);
            ext.push_back({other, 4'(ln)});
            repeat (ln + 1) ext.push_back(8'($urandom));
          end
        endcase
      end
    end
    while (ext.size() % 4 != 0) ext.push_back(8'h00);
    words = ext.size() / 4;

    // fixed header, SSRC, CSRC list, extension header, body, payload
    pkt_q.push_back({RTP_VERSION, 1'($urandom), 1'b1, 4'(n_csrc)});
    pkt_q.push_back({1'($urandom), sb.pt_match});
    repeat (10) pkt_q.push_back(8'($urandom));
    repeat (4 * n_csrc) pkt_q.push_back(8'($urandom));
    pkt_q.push_back(ONE_BYTE_PROFILE[15:8]);
    pkt_q.push_back(ONE_BYTE_PROFILE[7:0]);
    pkt_q.push_back(8'(words >> 8));
    pkt_q.push_back(8'(words));
    foreach (ext[i]) pkt_q.push_back(ext[i]);
    repeat ($urandom_range(0, 12)) pkt_q.push_back(8'($urandom));
    len_field = 16'(pkt_q.size());

    // damage
    case (fl)
      FL_VERSION: pkt_q[0] = {2'(($urandom_range(0, 2) + 3) % 4), pkt_q[0][5:0]};
      FL_XBIT:    pkt_q[0] = pkt_q[0] & 8'hEF;
      FL_PT:      pkt_q[1] = {pkt_q[1][7], 7'(sb.pt_match + 7'($urandom_range(1, 127)))};
      FL_CSRC_OVER: begin
        pkt_q[0] = pkt_q[0] | 8'h0F;
        while (pkt_q.size() > 71) void'(pkt_q.pop_back());
        len_field = 16'(pkt_q.size());
      end
      FL_EXT_SHORT: begin
        cut = e0 + $urandom_range(0, 3);
        while (pkt_q.size() > cut) void'(pkt_q.pop_back());
        len_field = 16'(pkt_q.size());
      end
      FL_EXT_LONG: pkt_q[e0 + 2] = 8'($urandom_range(1, 255));
      FL_PROFILE: begin
        idx = e0 + $urandom_range(0, 1);
        pkt_q[idx] = pkt_q[idx] ^ (8'd1 << $urandom_range(0, 7));
      end
      FL_EXT_EMPTY: begin
        pkt_q[e0 + 2] = 8'h00;
        pkt_q[e0 + 3] = 8'h00;
      end
      FL_OVERRUN: if (ext.size() != 0) pkt_q[e0 + 4] = {other, 4'hF};
      FL_EARLY_LAST: begin
        orig = pkt_q.size();
        cut  = $urandom_range(1, orig - 1);
        while (pkt_q.size() > cut) void'(pkt_q.pop_back());
        len_field = 16'($urandom_range(orig, 65535));
      end
      FL_LEN_MISMATCH: len_field = 16'($urandom_range(1, 65535));
      default: ;
    endcase
  endfunction

  function automatic flaw_t pick_flaw();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return FL_NONE;
    if (r < 66) return FL_NOISE;
    return flaw_t'($urandom_range(FL_VERSION, FL_LEN_MISMATCH));
  endfunction

  initial begin
    int sent;
    rst               = 1'b1;
    pkt.valid         = 1'b0;
    pkt.in_byte       = '0;
    pkt.in_last       = 1'b0;
    pkt.packet_length = '0;
    pkt.want_voice    = 1'b0;
    report.ready      = 1'b0;
    cfg.valid         = 1'b0;
    cfg.index         = CFG_REWRITE;
    cfg.data          = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: one-byte packet, short packet of all ones, then one packet
    // per damage kind with a fixed extension, under reset settings
    pkt_q = '{8'h00};
    len_field = 16'd1;
    send_packet(1'b0);
    pkt_q.delete();
    repeat (11) pkt_q.push_back(8'hFF);
    len_field = 16'hFFFF;
    send_packet(1'b1);
    for (int i = FL_NONE; i <= FL_LEN_MISMATCH; i++) begin
      build_packet(flaw_t'(i), (i % 2) ? 8'h00 : 8'hFF);
      send_packet(i % 2);
    end
    settle();

    // Directed: rewrite both ways, then level ids that can never match
    set_config(1'b1, 7'd0, 4'd14);
    build_packet(FL_NONE, 8'hFF);
    send_packet(1'b0);
    build_packet(FL_NONE, 8'h00);
    send_packet(1'b1);
    settle();
    set_config(1'b1, 7'd127, 4'd15);
    build_packet(FL_NONE, 8'h55);
    send_packet(1'b0);
    settle();
    set_config(1'b0, 7'd127, 4'd0);
    build_packet(FL_NONE, 8'hAA);
    send_packet(1'b1);
    settle();

    // Random phases across settings and idle patterns
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 52; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 52; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      case (ph)
        0: set_config(1'b1, 7'd127, 4'd14);
        1: set_config(1'b0, 7'd0, 4'd1);
        2: set_config(1'b1, 7'd111, 4'd15);
        3: set_config(1'b0, 7'd64, 4'd0);
        default: set_config(1'($urandom), 7'($urandom), 4'($urandom_range(1, 14)));
      endcase
      // long report stall while bytes keep coming
      if (ph == 1) hold_cycles = 400;
      sent = 0;
      while (sent < 190) begin
        build_packet(pick_flaw(), -1);
        send_packet(1'($urandom));
        sent += pkt_q.size();
      end
      settle();
    end

    repeat (10) @(posedge clk);
    if (sb.failures == 0 && sb.pending_reports.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
